/* rtl/cfr_pkg.sv */
// cfr_pkg: shared types and constants of the checksummed frame receiver
// used by cfr_ctrl and checksummed_frame_receiver; no dependencies
package cfr_pkg;

	// default payload length of one frame
	localparam int FRAME_DATA_LEN_DEF = 11;

	// register reset values
	localparam logic [7:0] HEADER_RST = 8'hA5;
	localparam logic [7:0] TAIL_RST   = 8'h5A;

	// configuration register indexes
	localparam logic CFG_HEADER = 1'b0;
	localparam logic CFG_TAIL   = 1'b1;

	// parser phases, plus the phase that drains a good frame
	typedef enum logic [2:0] {
		PH_WAIT,
		PH_DATA,
		PH_SUM,
		PH_TAIL,
		PH_EMIT
	} phase_t;

	// control from the sequencer to the cell chain and the ports
	typedef struct packed {
		logic in_ready;
		logic out_valid;
		logic shift;
		logic last_byte;
	} ctrl_t;

endpackage

/* rtl/cfr_cell.sv */
// cfr_cell: one byte cell of the payload chain
// takes its neighbor's byte on every shift; no package needed
module cfr_cell (
	input  logic       clk,
	input  logic       shift,
	input  logic [7:0] d,
	output logic [7:0] q
);

	logic [7:0] byte_q;

	// payload storage, no reset needed
	always_ff @(posedge clk) begin
		if (shift) begin
			byte_q <= d;
		end
	end

	assign q = byte_q;

endmodule

/* rtl/cfr_ctrl.sv */
// cfr_ctrl: frame parsing sequencer with running checksum and byte counter
// depends on cfr_pkg for phase_t and ctrl_t
module cfr_ctrl #(
	parameter int FRAME_DATA_LEN = cfr_pkg::FRAME_DATA_LEN_DEF,
	localparam int IDX_W = (FRAME_DATA_LEN > 1) ? $clog2(FRAME_DATA_LEN) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [7:0]         rx_byte,
	input  logic               out_ready,
	input  logic [7:0]         header_value,
	input  logic [7:0]         tail_value,
	output cfr_pkg::ctrl_t     ctrl,
	output logic [IDX_W-1:0]   idx
);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_DATA_LEN - 1);

	cfr_pkg::phase_t phase_q, phase_d;
	logic [IDX_W-1:0] cnt_q;
	logic [7:0]       sum_q;
	logic             chk_ok_q;
	logic             in_acc;
	logic             out_acc;
	logic             cnt_last;

	assign in_acc   = in_valid & ctrl.in_ready;
	assign out_acc  = ctrl.out_valid & out_ready;
	assign cnt_last = (cnt_q == LAST_IDX);

	// next phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			cfr_pkg::PH_WAIT: begin
				if (in_acc && rx_byte == header_value) phase_d = cfr_pkg::PH_DATA;
			end
			cfr_pkg::PH_DATA: begin
				if (in_acc && cnt_last) phase_d = cfr_pkg::PH_SUM;
			end
			cfr_pkg::PH_SUM: begin
				if (in_acc) phase_d = cfr_pkg::PH_TAIL;
			end
			cfr_pkg::PH_TAIL: begin
				if (in_acc) begin
					phase_d = (rx_byte == tail_value && chk_ok_q) ?
						cfr_pkg::PH_EMIT : cfr_pkg::PH_WAIT;
				end
			end
			cfr_pkg::PH_EMIT: begin
				if (out_acc && cnt_last) phase_d = cfr_pkg::PH_WAIT;
			end
			default: phase_d = cfr_pkg::PH_WAIT;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		ctrl = '0;
		unique case (phase_q)
			cfr_pkg::PH_WAIT: begin
				ctrl.in_ready = 1'b1;
			end
			cfr_pkg::PH_SUM: begin
				ctrl.in_ready = 1'b1;
			end
			cfr_pkg::PH_TAIL: begin
				ctrl.in_ready = 1'b1;
			end
			cfr_pkg::PH_DATA: begin
				ctrl.in_ready = 1'b1;
				ctrl.shift    = in_valid;
			end
			cfr_pkg::PH_EMIT: begin
				ctrl.out_valid = 1'b1;
				ctrl.shift     = out_ready;
				ctrl.last_byte = cnt_last;
			end
			default: ctrl = '0;
		endcase
	end

	// phase register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= cfr_pkg::PH_WAIT;
		end else begin
			phase_q <= phase_d;
		end
	end

	// byte counter, running payload sum and checksum match
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			sum_q    <= '0;
			chk_ok_q <= 1'b0;
		end else begin
			case (phase_q)
				cfr_pkg::PH_WAIT: begin
					if (in_acc && rx_byte == header_value) begin
						cnt_q <= '0;
						sum_q <= '0;
					end
				end
				cfr_pkg::PH_DATA: begin
					if (in_acc) begin
						cnt_q <= cnt_last ? '0 : cnt_q + 1'b1;
						sum_q <= sum_q + rx_byte;
					end
				end
				cfr_pkg::PH_SUM: begin
					if (in_acc) chk_ok_q <= (rx_byte == sum_q);
				end
				cfr_pkg::PH_EMIT: begin
					if (out_acc) cnt_q <= cnt_last ? '0 : cnt_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign idx = cnt_q;

endmodule

/* rtl/checksummed_frame_receiver.sv */
// checksummed_frame_receiver: header, payload, checksum, tail frame parser
// one input byte per cycle; a good frame drains FRAME_DATA_LEN results, one a cycle
// while out_ready; the first is valid the cycle after the tail byte is accepted
// input is stalled while the payload chain drains (FRAME_DATA_LEN transactions out)
// arst_n clears the phase, counter and sum and restores header 0xA5 and tail 0x5A
// depends on cfr_pkg, cfr_ctrl and cfr_cell
module checksummed_frame_receiver #(
	parameter int FRAME_DATA_LEN = cfr_pkg::FRAME_DATA_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] data_byte,
	output logic [3:0] byte_index,
	output logic       last_byte
);

	localparam int IDX_W = (FRAME_DATA_LEN > 1) ? $clog2(FRAME_DATA_LEN) : 1;

	logic [7:0]       header_q;
	logic [7:0]       tail_q;
	cfr_pkg::ctrl_t   ctrl;
	logic [IDX_W-1:0] idx;
	logic [IDX_W+3:0] idx_ext;
	logic [7:0]       chain [FRAME_DATA_LEN];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= cfr_pkg::HEADER_RST;
			tail_q   <= cfr_pkg::TAIL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cfr_pkg::CFG_HEADER: header_q <= cfg_data;
				cfr_pkg::CFG_TAIL:   tail_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	cfr_ctrl #(
		.FRAME_DATA_LEN(FRAME_DATA_LEN)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.rx_byte     (rx_byte),
		.out_ready   (out_ready),
		.header_value(header_q),
		.tail_value  (tail_q),
		.ctrl        (ctrl),
		.idx         (idx)
	);

	// payload chain: bytes enter at cell zero, the oldest sits at the far end
	for (genvar k = 0; k < FRAME_DATA_LEN; k++) begin : g_cell
		if (k == 0) begin : g_head
			cfr_cell u_cell (
				.clk  (clk),
				.shift(ctrl.shift),
				.d    (rx_byte),
				.q    (chain[k])
			);
		end else begin : g_body
			cfr_cell u_cell (
				.clk  (clk),
				.shift(ctrl.shift),
				.d    (chain[k-1]),
				.q    (chain[k])
			);
		end
	end

	// output transaction fields
	assign idx_ext    = {4'b0000, idx};
	assign in_ready   = ctrl.in_ready;
	assign out_valid  = ctrl.out_valid;
	assign data_byte  = chain[FRAME_DATA_LEN-1];
	assign byte_index = idx_ext[3:0];
	assign last_byte  = ctrl.last_byte;

endmodule
